>>> rtl/lfpd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lfpd_pkg;

   // framing bytes
   localparam logic [7:0] SYNC_FIRST   = 8'h83;
   localparam logic [7:0] SYNC_SECOND  = 8'h84;
   localparam logic [7:0] TRAIL_FIRST  = 8'hF4;
   localparam logic [7:0] TRAIL_SECOND = 8'h4F;

   // sync, command, length and ID bytes ahead of the payload
   localparam int unsigned HEADER_BYTES = 11;
   // header plus the two trailer bytes
   localparam logic [31:0] MIN_FRAME = 32'(HEADER_BYTES + 2);

   localparam logic [7:0] IDLE_COMMAND = 8'hFF;

   // result status codes
   localparam logic [1:0] ST_PAYLOAD = 2'd0;
   localparam logic [1:0] ST_GOOD    = 2'd1;
   localparam logic [1:0] ST_BAD     = 2'd2;

   typedef enum logic [3:0] {
      PH_HUNT1   = 4'd0,
      PH_HUNT2   = 4'd1,
      PH_CMD     = 4'd2,
      PH_LEN     = 4'd3,
      PH_ID      = 4'd4,
      PH_PAYLOAD = 4'd5,
      PH_TRAIL1  = 4'd6,
      PH_TRAIL2  = 4'd7
   } phase_type;

   typedef struct packed {
      logic [7:0]  payload_byte;
      logic [7:0]  command;
      logic [31:0] node_id;
      logic [1:0]  frame_status;
      logic        last;
   } result_type;

endpackage
`default_nettype wire

>>> rtl/lfpd_if.sv
`timescale 1ns / 1ps
`default_nettype none

// received byte channel
interface lfpd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

// parsed result channel
interface lfpd_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  payload_byte;
   logic [7:0]  command;
   logic [31:0] node_id;
   logic [1:0]  frame_status;
   logic        last;

   modport source (output valid, output payload_byte, output command, output node_id,
                   output frame_status, output last, input ready);
   modport sink (input valid, input payload_byte, input command, input node_id,
                 input frame_status, input last, output ready);
endinterface

`default_nettype wire

>>> rtl/lfpd_parser.sv
`timescale 1ns / 1ps
`default_nettype none
module lfpd_parser (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               fire,
   input  wire logic [7:0]         rx_byte,
   output logic                    push,
   output lfpd_pkg::result_type    result
);
   import lfpd_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [1:0]  idx_ff, idx_in;
   logic [31:0] len_ff, len_in;
   logic [31:0] remain_ff, remain_in;
   logic [7:0]  cmd_ff, cmd_in;
   logic [31:0] id_ff, id_in;
   logic        trail_ok_ff, trail_ok_in;

   logic [31:0] len_shift;
   logic [31:0] id_shift;

   assign len_shift = {len_ff[23:0], rx_byte};
   assign id_shift  = {id_ff[23:0], rx_byte};

   // parse state register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HUNT1;
         idx_ff      <= 2'd0;
         len_ff      <= '0;
         remain_ff   <= '0;
         cmd_ff      <= IDLE_COMMAND;
         id_ff       <= '0;
         trail_ok_ff <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         idx_ff      <= idx_in;
         len_ff      <= len_in;
         remain_ff   <= remain_in;
         cmd_ff      <= cmd_in;
         id_ff       <= id_in;
         trail_ok_ff <= trail_ok_in;
      end
   end

   // next state and result for one accepted byte
   always_comb begin
      phase_in    = phase_ff;
      idx_in      = idx_ff;
      len_in      = len_ff;
      remain_in   = remain_ff;
      cmd_in      = cmd_ff;
      id_in       = id_ff;
      trail_ok_in = trail_ok_ff;
      push        = 1'b0;
      result.payload_byte = 8'd0;
      result.command      = cmd_ff;
      result.node_id      = id_ff;
      result.frame_status = ST_BAD;
      result.last         = 1'b1;
      if (fire) begin
         unique case (phase_ff)
            PH_HUNT1: begin
               if (rx_byte == SYNC_FIRST) phase_in = PH_HUNT2;
            end
            PH_HUNT2: begin
               if (rx_byte == SYNC_SECOND) begin
                  phase_in = PH_CMD;
               end else if (rx_byte != SYNC_FIRST) begin
                  phase_in = PH_HUNT1;
               end
            end
            PH_CMD: begin
               cmd_in   = rx_byte;
               id_in    = '0;
               len_in   = '0;
               idx_in   = 2'd0;
               phase_in = PH_LEN;
            end
            PH_LEN: begin
               len_in = len_shift;
               idx_in = idx_ff + 2'd1;
               if (idx_ff == 2'd3) begin
                  if (len_shift < MIN_FRAME) begin
                     // too short: bad end right away
                     push            = 1'b1;
                     result.node_id  = id_ff;
                     cmd_in          = IDLE_COMMAND;
                     phase_in        = PH_HUNT1;
                  end else begin
                     remain_in = len_shift - MIN_FRAME;
                     phase_in  = PH_ID;
                  end
               end
            end
            PH_ID: begin
               id_in  = id_shift;
               idx_in = idx_ff + 2'd1;
               if (idx_ff == 2'd3) begin
                  phase_in = (remain_ff == '0) ? PH_TRAIL1 : PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               push                = 1'b1;
               result.payload_byte = rx_byte;
               result.frame_status = ST_PAYLOAD;
               result.last         = 1'b0;
               remain_in           = remain_ff - 32'd1;
               if (remain_ff == 32'd1) phase_in = PH_TRAIL1;
            end
            PH_TRAIL1: begin
               trail_ok_in = (rx_byte == TRAIL_FIRST);
               phase_in    = PH_TRAIL2;
            end
            PH_TRAIL2: begin
               push = 1'b1;
               result.frame_status = (trail_ok_ff && rx_byte == TRAIL_SECOND) ?
                                     ST_GOOD : ST_BAD;
               cmd_in      = IDLE_COMMAND;
               trail_ok_in = 1'b0;
               phase_in    = PH_HUNT1;
            end
            default: begin
               phase_in = PH_HUNT1;
            end
         endcase
      end
   end

   // a frame end always drops back to hunting
   a_end_to_hunt: assert property (@(posedge clock) disable iff (reset)
      push && result.last |=> phase_ff == PH_HUNT1 && cmd_ff == IDLE_COMMAND)
      else $error("frame end did not return to hunting");

   // results without the last flag always carry payload status
   a_payload_not_last: assert property (@(posedge clock) disable iff (reset)
      push && !result.last |-> result.frame_status == ST_PAYLOAD)
      else $error("non-final result with end status");

   // second trailer byte always yields an end result
   a_trailer_emits: assert property (@(posedge clock) disable iff (reset)
      fire && phase_ff == PH_TRAIL2 |-> push && result.last)
      else $error("trailer byte gave no end result");

endmodule
`default_nettype wire

>>> rtl/lfpd_out_buf.sv
`timescale 1ns / 1ps
`default_nettype none
module lfpd_out_buf (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire lfpd_pkg::result_type push_data,
   output logic                    space,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output lfpd_pkg::result_type    out_data
);
   import lfpd_pkg::*;

   result_type head_ff, head_in;
   result_type skid_ff, skid_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       pop;

   assign space     = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = head_ff;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   // output register plus one skid entry
   always_comb begin
      head_in = head_ff;
      skid_in = skid_ff;
      cnt_in  = cnt_ff;
      unique case (cnt_ff)
         2'd0: begin
            if (push) begin
               head_in = push_data;
               cnt_in  = 2'd1;
            end
         end
         2'd1: begin
            if (push && pop) begin
               head_in = push_data;
            end else if (push) begin
               skid_in = push_data;
               cnt_in  = 2'd2;
            end else if (pop) begin
               cnt_in = 2'd0;
            end
         end
         2'd2: begin
            if (pop) begin
               head_in = skid_ff;
               cnt_in  = 2'd1;
            end
         end
         default: begin
            cnt_in = 2'd0;
         end
      endcase
   end

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("output buffer count out of range");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd2 |-> !push)
      else $error("push into full output buffer");

   a_skid_drain: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd2 && pop |=> cnt_ff == 2'd1 && head_ff == $past(skid_ff))
      else $error("skid entry not moved to head");

endmodule
`default_nettype wire

>>> rtl/length_framed_packet_deframer.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel  Dir  Payload                                                   Handshake
// req_if   in   rx_byte[7:0]                                              valid/ready
// rsp_if   out  payload_byte[7:0] command[7:0] node_id[31:0]             valid/ready
//               frame_status[1:0] last
//
// One byte per cycle while req_if.ready is high: each accepted byte advances
// the parse state, and any result enters the output stage at that same edge.
// Reset is synchronous and returns the parser to hunting the first sync byte.
// A two-entry output stage (register plus skid) keeps req_if.ready high
// while one result waits; ready drops only when both entries are full.
module length_framed_packet_deframer (
   input wire logic  clock,
   input wire logic  reset,
   lfpd_req_if.sink  req_if,
   lfpd_rsp_if.source rsp_if
);
   import lfpd_pkg::*;

   logic       fire;
   logic       push;
   logic       space;
   result_type result;
   result_type out_data;

   assign req_if.ready = space;
   assign fire         = req_if.valid && space;

   lfpd_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .rx_byte (req_if.rx_byte),
      .push    (push),
      .result  (result)
   );

   lfpd_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (result),
      .space     (space),
      .out_valid (rsp_if.valid),
      .out_ready (rsp_if.ready),
      .out_data  (out_data)
   );

   assign rsp_if.payload_byte = out_data.payload_byte;
   assign rsp_if.command      = out_data.command;
   assign rsp_if.node_id      = out_data.node_id;
   assign rsp_if.frame_status = out_data.frame_status;
   assign rsp_if.last         = out_data.last;

endmodule
`default_nettype wire
